### rtl/rswt_pkg.sv
// ---------------------------------------------------------------------------
// rswt_pkg: shared types and constants for the recent send window tracker
// Field widths, controller states and the command / status bundles that
// join the sequencer and the datapath.
// ---------------------------------------------------------------------------
package rswt_pkg;

    localparam int RING_SLOTS_DEF = 32;
    localparam int HASH_W         = 32;
    localparam int STAMP_W        = 32;
    localparam int WIN_W          = 32;
    localparam int COUNT_W        = 6;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;
    localparam logic [WIN_W-1:0]   WIN_RESET = 32'd60;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_WRITE,
        ST_OUTER_RD,
        ST_OUTER_EV,
        ST_INNER,
        ST_INNER_END,
        ST_INNER_DEC,
        ST_NEXT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;        // capture the input word
        logic scan;        // issue one lookup read
        logic write;       // store the message in its slot
        logic outer_rd;    // read the slot under the outer index
        logic outer_eval;  // evaluate that slot
        logic inner_rd;    // read one earlier slot for the duplicate check
        logic dist_inc;    // count a first occurrence of a target
        logic next_i;      // step the outer index
        logic emit;        // load the result register
    } cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic i_last;
        logic i_zero;
        logic inner_last;
        logic live_i;
        logic seen;
        logic out_free;
    } stat_t;

endpackage

### rtl/rswt_ctrl.sv
// ---------------------------------------------------------------------------
// rswt_ctrl: sequencer
// Steps through lookup, slot write and the pairwise count over the ring.
// ---------------------------------------------------------------------------
module rswt_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    output rswt_pkg::cmd_t  cmd,
    input  rswt_pkg::stat_t stat
);
    import rswt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.cnt_last) begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:  state_next = ST_WRITE;
            ST_WRITE:     state_next = ST_OUTER_RD;
            ST_OUTER_RD:  state_next = ST_OUTER_EV;
            ST_OUTER_EV: begin
                if (stat.live_i && !stat.i_zero) begin
                    state_next = ST_INNER;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_INNER: begin
                if (stat.inner_last) begin
                    state_next = ST_INNER_END;
                end
            end
            ST_INNER_END: state_next = ST_INNER_DEC;
            ST_INNER_DEC: state_next = ST_NEXT;
            ST_NEXT: begin
                if (stat.i_last) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_OUTER_RD;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SCAN:     cmd.scan = 1'b1;
            ST_WRITE:    cmd.write = 1'b1;
            ST_OUTER_RD: cmd.outer_rd = 1'b1;
            ST_OUTER_EV: begin
                cmd.outer_eval = 1'b1;
                // slot 0 has nothing before it
                cmd.dist_inc   = stat.live_i && stat.i_zero;
            end
            ST_INNER:     cmd.inner_rd = 1'b1;
            ST_INNER_DEC: cmd.dist_inc = !stat.seen;
            ST_NEXT:      cmd.next_i = 1'b1;
            ST_DONE:      cmd.emit = stat.out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

### rtl/rswt_dp.sv
// ---------------------------------------------------------------------------
// rswt_dp: datapath
// Slot memories, live and text-match flags, indices, counters and the
// result register.
// ---------------------------------------------------------------------------
module rswt_dp #(
    parameter int RING_SLOTS = rswt_pkg::RING_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rswt_pkg::cmd_t                cmd,
    output rswt_pkg::stat_t               stat,
    input  logic [rswt_pkg::HASH_W-1:0]   in_target,
    input  logic [rswt_pkg::HASH_W-1:0]   in_text,
    input  logic [rswt_pkg::STAMP_W-1:0]  in_now,
    input  logic [rswt_pkg::WIN_W-1:0]    window,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rswt_pkg::COUNT_W-1:0]  out_distinct,
    output logic [rswt_pkg::COUNT_W-1:0]  out_same
);
    import rswt_pkg::*;

    localparam int IDX_W = $clog2(RING_SLOTS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_SLOTS - 1);

    logic [HASH_W-1:0]  target_mem [RING_SLOTS];
    logic [HASH_W-1:0]  text_mem   [RING_SLOTS];
    logic [STAMP_W-1:0] stamp_mem  [RING_SLOTS];

    logic [HASH_W-1:0]  rd_target_reg, rd_text_reg;
    logic [STAMP_W-1:0] rd_stamp_reg;

    logic [HASH_W-1:0]  tg_reg, tg_next, tx_reg, tx_next, ti_reg, ti_next;
    logic [STAMP_W-1:0] now_reg, now_next;

    logic [RING_SLOTS-1:0] valid_reg, valid_next;
    logic [RING_SLOTS-1:0] live_reg, live_next;
    logic [RING_SLOTS-1:0] txm_reg, txm_next;

    logic [IDX_W-1:0] head_reg, head_next, hit_reg, hit_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next, i_reg, i_next, tag_reg, tag_next;
    logic             found_reg, found_next, seen_reg, seen_next;
    logic             scan_pv_reg, scan_pv_next, inner_pv_reg, inner_pv_next;

    logic [COUNT_W-1:0] dist_reg, dist_next, same_reg, same_next;
    logic [COUNT_W-1:0] out_dist_reg, out_dist_next, out_same_reg, out_same_next;
    logic               out_vld_reg, out_vld_next;

    logic [IDX_W-1:0]   rd_addr, wr_slot;
    logic [STAMP_W-1:0] eff_stamp;
    logic [STAMP_W:0]   age;
    logic               in_win, slot_live, key_hit;

    assign rd_addr = cmd.outer_rd ? i_reg : cnt_reg;
    assign wr_slot = found_reg ? hit_reg : head_reg;

    // never-written slots read as empty
    assign eff_stamp = valid_reg[tag_reg] ? rd_stamp_reg : '0;
    assign age       = {1'b0, now_reg} - {1'b0, eff_stamp};
    assign in_win    = $signed(age) <= $signed({1'b0, window});
    assign slot_live = (eff_stamp != '0) && in_win;
    assign key_hit   = (eff_stamp != '0) && (rd_target_reg == tg_reg)
                       && (rd_text_reg == tx_reg);

    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            target_mem[wr_slot] <= tg_reg;
            text_mem[wr_slot]   <= tx_reg;
            stamp_mem[wr_slot]  <= now_reg;
        end
        rd_target_reg <= target_mem[rd_addr];
        rd_text_reg   <= text_mem[rd_addr];
        rd_stamp_reg  <= stamp_mem[rd_addr];
    end

    always_comb begin
        tg_next       = tg_reg;
        tx_next       = tx_reg;
        now_next      = now_reg;
        ti_next       = ti_reg;
        valid_next    = valid_reg;
        live_next     = live_reg;
        txm_next      = txm_reg;
        head_next     = head_reg;
        hit_next      = hit_reg;
        found_next    = found_reg;
        seen_next     = seen_reg;
        cnt_next      = cnt_reg;
        i_next        = i_reg;
        tag_next      = rd_addr;
        scan_pv_next  = cmd.scan;
        inner_pv_next = cmd.inner_rd;
        dist_next     = dist_reg;
        same_next     = same_reg;
        out_dist_next = out_dist_reg;
        out_same_next = out_same_reg;
        out_vld_next  = out_vld_reg;

        if (cmd.load) begin
            tg_next    = in_target;
            tx_next    = in_text;
            now_next   = in_now;
            found_next = 1'b0;
            cnt_next   = '0;
        end

        if (cmd.scan && cnt_reg != IDX_LAST) begin
            cnt_next = cnt_reg + 1'b1;
        end

        // lookup data returns in the cycle after its read
        if (scan_pv_reg) begin
            live_next[tag_reg] = slot_live;
            txm_next[tag_reg]  = (rd_text_reg == tx_reg);
            if (key_hit && !found_reg) begin
                found_next = 1'b1;
                hit_next   = tag_reg;
            end
        end

        if (cmd.write) begin
            valid_next[wr_slot] = 1'b1;
            live_next[wr_slot]  = (now_reg != '0);
            txm_next[wr_slot]   = 1'b1;
            if (!found_reg) begin
                head_next = (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;
            end
            i_next    = '0;
            dist_next = '0;
            same_next = '0;
        end

        if (cmd.outer_eval) begin
            ti_next   = rd_target_reg;
            seen_next = 1'b0;
            cnt_next  = '0;
            if (live_reg[i_reg] && txm_reg[i_reg] && same_reg != COUNT_MAX) begin
                same_next = same_reg + 1'b1;
            end
        end

        if (cmd.inner_rd && cnt_reg != IDX_LAST) begin
            cnt_next = cnt_reg + 1'b1;
        end

        if (inner_pv_reg && live_reg[tag_reg] && rd_target_reg == ti_reg) begin
            seen_next = 1'b1;
        end

        if (cmd.dist_inc && dist_reg != COUNT_MAX) begin
            dist_next = dist_reg + 1'b1;
        end

        if (cmd.next_i && i_reg != IDX_LAST) begin
            i_next = i_reg + 1'b1;
        end

        if (cmd.emit) begin
            out_vld_next  = 1'b1;
            out_dist_next = dist_reg;
            out_same_next = same_reg;
        end else if (out_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            live_reg     <= '0;
            txm_reg      <= '0;
            head_reg     <= '0;
            hit_reg      <= '0;
            found_reg    <= 1'b0;
            seen_reg     <= 1'b0;
            cnt_reg      <= '0;
            i_reg        <= '0;
            tag_reg      <= '0;
            scan_pv_reg  <= 1'b0;
            inner_pv_reg <= 1'b0;
            dist_reg     <= '0;
            same_reg     <= '0;
            out_vld_reg  <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            live_reg     <= live_next;
            txm_reg      <= txm_next;
            head_reg     <= head_next;
            hit_reg      <= hit_next;
            found_reg    <= found_next;
            seen_reg     <= seen_next;
            cnt_reg      <= cnt_next;
            i_reg        <= i_next;
            tag_reg      <= tag_next;
            scan_pv_reg  <= scan_pv_next;
            inner_pv_reg <= inner_pv_next;
            dist_reg     <= dist_next;
            same_reg     <= same_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        tg_reg       <= tg_next;
        tx_reg       <= tx_next;
        now_reg      <= now_next;
        ti_reg       <= ti_next;
        out_dist_reg <= out_dist_next;
        out_same_reg <= out_same_next;
    end

    assign stat.cnt_last   = (cnt_reg == IDX_LAST);
    assign stat.i_last     = (i_reg == IDX_LAST);
    assign stat.i_zero     = (i_reg == '0);
    assign stat.inner_last = (cnt_reg == i_reg - 1'b1);
    assign stat.live_i     = live_reg[i_reg];
    assign stat.seen       = seen_reg;
    assign stat.out_free   = !out_vld_reg || out_ready;

    assign out_valid    = out_vld_reg;
    assign out_distinct = out_dist_reg;
    assign out_same     = out_same_reg;

endmodule

### rtl/recent_send_window_tracker.sv
// ---------------------------------------------------------------------------
// recent_send_window_tracker: ring of recently sent messages with counts
// Records one message per input word and reports distinct live targets and
// live slots carrying the same text.
// ---------------------------------------------------------------------------
// Usage:
//  s_ channel: one word per sent message (target hash, text hash, time).
//  m_ channel: one word per input: distinct live targets, same-text count.
//  cfg channel: window length in seconds, always ready; write only while
//  the block is idle. Reset value is 60.
//  Per word, N = RING_SLOTS: a lookup pass over all N slots, then an outer
//  pass that visits every slot, plus for each live slot i > 0 a duplicate
//  check against slots 0 to i-1 (it runs through the single read port of the
//  target memory). One word at a time; s_tready is high only between words.
//  The result sits in an output register: the next word is taken while it
//  waits, and that word's result is held back until m_tready frees it.
//  Reset empties every slot through per-slot valid flags, with no clearing
//  pass, and sets the head pointer to slot 0.
// ---------------------------------------------------------------------------
module recent_send_window_tracker #(
    parameter int RING_SLOTS = rswt_pkg::RING_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // target_hash, text_hash, now_seconds
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // unique_targets, same_text_count, zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data   // window_seconds
);
    import rswt_pkg::*;

    localparam int CNT_CAP = (RING_SLOTS < 63) ? RING_SLOTS : 63;

    logic [WIN_W-1:0]   win_reg, win_next;
    cmd_t               cmd;
    stat_t              stat;
    logic [COUNT_W-1:0] distinct, same;

    assign cfg_ready = 1'b1;
    assign win_next  = cfg_valid ? cfg_data : win_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= WIN_RESET;
        end else begin
            win_reg <= win_next;
        end
    end

    rswt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    rswt_dp #(
        .RING_SLOTS (RING_SLOTS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .in_target    (s_tdata[31:0]),
        .in_text      (s_tdata[63:32]),
        .in_now       (s_tdata[95:64]),
        .window       (win_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_distinct (distinct),
        .out_same     (same)
    );

    assign m_tdata = {4'b0000, same, distinct};

    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input word taken while one is in progress");

    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.emit))
        else $error("result appeared without an emit");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (distinct <= COUNT_W'(CNT_CAP) && same <= COUNT_W'(CNT_CAP)))
        else $error("count above ring size");

    a_same_needs_target: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && same != '0) |-> distinct != '0)
        else $error("live text match with no live target");

endmodule
